// File: rtl/core/rts_pkg.sv
// types, constants and byte class helpers for the rtf token splitter
// no dependencies; imported by every module of the block
package rts_pkg;

    localparam int TEXT_BYTE_W    = 8;
    localparam int TOKEN_LINE_W   = 24;
    localparam int TOKEN_COL_W    = 16;
    localparam int TOKEN_KIND_W   = 2;
    localparam int LINE_WIDTH_DEF = 24;
    localparam int COL_WIDTH_DEF  = 16;

    localparam logic [TEXT_BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [TEXT_BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [TEXT_BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [TEXT_BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [TEXT_BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [TEXT_BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [TEXT_BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [TEXT_BYTE_W-1:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_TEXT    = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_LETTERS = 3'd3,
        MODE_DIGITS  = 3'd4
    } t_scan_mode;

    typedef enum logic [TOKEN_KIND_W-1:0] {
        KIND_BRACE  = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_SYMBOL = 2'd2,
        KIND_TEXT   = 2'd3
    } t_token_kind;

    // counter update request from the scanner to the position tracker
    typedef struct packed {
        logic begin_tok;
        logic col_inc;
        logic col_clear;
        logic line_inc;
    } t_pos_cmd;

    // per-beat classification from the scanner
    typedef struct packed {
        logic        kept;
        logic        first;
        t_token_kind kind;
    } t_scan_result;

    function automatic logic is_letter(input logic [TEXT_BYTE_W-1:0] b);
        return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_digit(input logic [TEXT_BYTE_W-1:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

endpackage

// File: rtl/core/rts_scanner.sv
// token scanner: scan mode and end-of-text state, per-byte classification
// depends on rts_pkg
module rts_scanner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic [rts_pkg::TEXT_BYTE_W-1:0]   i_byte,
    output rts_pkg::t_scan_result             o_result,
    output rts_pkg::t_pos_cmd                 o_pos_cmd
);
    import rts_pkg::*;

    t_scan_mode r_mode, n_mode;
    logic       r_ended, n_ended;
    logic       w_between;

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_ended   = r_ended;
        w_between = 1'b0;
        if (r_ended) begin
            n_mode = r_mode;
        end else if (i_byte == CH_NUL) begin
            n_ended = 1'b1;
            n_mode  = MODE_BETWEEN;
        end else begin
            case (r_mode)
                MODE_ESCAPE: begin
                    n_mode = is_letter(i_byte) ? MODE_LETTERS : MODE_BETWEEN;
                end
                MODE_LETTERS: begin
                    if (is_letter(i_byte)) begin
                        n_mode = MODE_LETTERS;
                    end else if (i_byte == CH_MINUS || is_digit(i_byte)) begin
                        n_mode = MODE_DIGITS;
                    end else if (i_byte == CH_SPACE) begin
                        n_mode = MODE_BETWEEN;
                    end else begin
                        w_between = 1'b1;
                    end
                end
                MODE_DIGITS: begin
                    if (is_digit(i_byte)) begin
                        n_mode = MODE_DIGITS;
                    end else if (i_byte == CH_SPACE) begin
                        n_mode = MODE_BETWEEN;
                    end else begin
                        w_between = 1'b1;
                    end
                end
                MODE_TEXT: begin
                    if (i_byte inside {CH_BSLASH, CH_LBRACE, CH_RBRACE, CH_CR, CH_LF}) begin
                        w_between = 1'b1;
                    end
                end
                default: begin
                    w_between = 1'b1;
                end
            endcase
            if (w_between) begin
                case (i_byte)
                    CH_LF, CH_CR, CH_LBRACE, CH_RBRACE: n_mode = MODE_BETWEEN;
                    CH_BSLASH:                          n_mode = MODE_ESCAPE;
                    default:                            n_mode = MODE_TEXT;
                endcase
            end
        end
    end

    // outputs
    always_comb begin
        o_result  = '{kept: 1'b0, first: 1'b0, kind: KIND_BRACE};
        o_pos_cmd = '0;
        if (!r_ended && i_byte != CH_NUL) begin
            case (r_mode)
                MODE_ESCAPE: begin
                    o_pos_cmd.col_inc = 1'b1;
                    o_result.kept     = 1'b1;
                    o_result.kind     = is_letter(i_byte) ? KIND_WORD : KIND_SYMBOL;
                    if (i_byte == CH_LF) begin
                        o_pos_cmd.line_inc  = 1'b1;
                        o_pos_cmd.col_clear = 1'b1;
                    end
                end
                MODE_LETTERS, MODE_DIGITS: begin
                    if (!w_between) begin
                        o_pos_cmd.col_inc = 1'b1;
                        if (i_byte != CH_SPACE) begin
                            o_result.kept = 1'b1;
                            o_result.kind = KIND_WORD;
                        end
                    end
                end
                MODE_TEXT: begin
                    if (!w_between) begin
                        o_pos_cmd.col_inc = 1'b1;
                        o_result.kept     = 1'b1;
                        o_result.kind     = KIND_TEXT;
                    end
                end
                default: begin
                    o_result.kept = 1'b0;
                end
            endcase
            if (w_between) begin
                case (i_byte)
                    CH_LF: begin
                        o_pos_cmd.line_inc  = 1'b1;
                        o_pos_cmd.col_clear = 1'b1;
                    end
                    CH_CR: begin
                        o_result.kept = 1'b0;
                    end
                    CH_LBRACE, CH_RBRACE: begin
                        o_pos_cmd.begin_tok = 1'b1;
                        o_result = '{kept: 1'b1, first: 1'b1, kind: KIND_BRACE};
                    end
                    CH_BSLASH: begin
                        o_pos_cmd.begin_tok = 1'b1;
                        o_result = '{kept: 1'b1, first: 1'b1, kind: KIND_SYMBOL};
                    end
                    default: begin
                        o_pos_cmd.begin_tok = 1'b1;
                        o_result = '{kept: 1'b1, first: 1'b1, kind: KIND_TEXT};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BETWEEN;
            r_ended <= 1'b0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_ended <= n_ended;
        end
    end

endmodule

// File: rtl/core/rts_position.sv
// saturating line and column counters and token start position
// depends on rts_pkg
module rts_position #(
    parameter int LINE_WIDTH   = rts_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = rts_pkg::COL_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  rts_pkg::t_pos_cmd       i_cmd,
    output logic [LINE_WIDTH-1:0]   o_tok_line,
    output logic [COLUMN_WIDTH-1:0] o_tok_col
);
    import rts_pkg::*;

    logic [LINE_WIDTH-1:0]   r_line, n_line, r_start_line, n_start_line;
    logic [COLUMN_WIDTH-1:0] r_col, n_col, r_start_col, n_start_col;

    always_comb begin
        n_line       = r_line;
        n_col        = r_col;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        if (i_cmd.begin_tok) begin
            n_start_line = r_line;
            n_start_col  = r_col;
        end
        if (i_cmd.line_inc && r_line != '1) begin
            n_line = r_line + LINE_WIDTH'(1);
        end
        if (i_cmd.col_clear) begin
            n_col = '0;
        end else if ((i_cmd.col_inc || i_cmd.begin_tok) && r_col != '1) begin
            n_col = r_col + COLUMN_WIDTH'(1);
        end
    end

    assign o_tok_line = n_start_line;
    assign o_tok_col  = n_start_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= '0;
            r_col        <= '0;
            r_start_line <= '0;
            r_start_col  <= '0;
        end else if (i_advance) begin
            r_line       <= n_line;
            r_col        <= n_col;
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
        end
    end

endmodule

// File: rtl/core/rtf_token_splitter.sv
// top level of the rtf token splitter: input register, scanner, position, result register
// depends on rts_pkg, rts_scanner, rts_position
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+----------------------------------------------
//  in      | i_in_valid | o_in_stall | i_text_byte
//  out     | o_out_valid| i_out_stall| o_out_byte o_kept o_token_first o_token_kind
//          |            |            | o_token_line o_token_column
//
// one beat per cycle sustained while the output is not stalled
// the per-byte scan sits between the input register and the result register
// synchronous active-low reset returns to between tokens at line 0, column 0
// a stalled output holds the result; the input register still drains into the
// result register whenever it is empty or being taken
module rtf_token_splitter #(
    parameter int LINE_WIDTH   = rts_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = rts_pkg::COL_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [rts_pkg::TEXT_BYTE_W-1:0]    i_text_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [rts_pkg::TEXT_BYTE_W-1:0]    o_out_byte,
    output logic                               o_kept,
    output logic                               o_token_first,
    output logic [rts_pkg::TOKEN_KIND_W-1:0]   o_token_kind,
    output logic [rts_pkg::TOKEN_LINE_W-1:0]   o_token_line,
    output logic [rts_pkg::TOKEN_COL_W-1:0]    o_token_column
);
    import rts_pkg::*;

    logic                     r_in_valid;
    logic [TEXT_BYTE_W-1:0]   r_in_byte;
    logic                     w_advance;
    logic                     w_in_accept;
    t_scan_result             w_result;
    t_pos_cmd                 w_pos_cmd;
    logic [LINE_WIDTH-1:0]    w_tok_line;
    logic [COLUMN_WIDTH-1:0]  w_tok_col;
    logic [63:0]              w_line_ext;
    logic [63:0]              w_col_ext;

    logic                     r_out_valid;
    logic [TEXT_BYTE_W-1:0]   r_out_byte;
    logic                     r_kept;
    logic                     r_first;
    logic [TOKEN_KIND_W-1:0]  r_kind;
    logic [TOKEN_LINE_W-1:0]  r_line, n_line;
    logic [TOKEN_COL_W-1:0]   r_col, n_col;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    rts_scanner u_scanner (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .o_result  (w_result),
        .o_pos_cmd (w_pos_cmd)
    );

    rts_position #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_position (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_cmd      (w_pos_cmd),
        .o_tok_line (w_tok_line),
        .o_tok_col  (w_tok_col)
    );

    assign w_line_ext = 64'(w_tok_line);
    assign w_col_ext  = 64'(w_tok_col);

    // dropped beats report zero position
    always_comb begin
        n_line = '0;
        n_col  = '0;
        if (w_result.kept) begin
            n_line = w_line_ext[TOKEN_LINE_W-1:0];
            n_col  = w_col_ext[TOKEN_COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= i_text_byte;
        end
        if (w_advance) begin
            r_out_byte <= r_in_byte;
            r_kept     <= w_result.kept;
            r_first    <= w_result.first;
            r_kind     <= w_result.kind;
            r_line     <= n_line;
            r_col      <= n_col;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_kept         = r_kept;
    assign o_token_first  = r_first;
    assign o_token_kind   = r_kind;
    assign o_token_line   = r_line;
    assign o_token_column = r_col;

endmodule

// File: test/tb_rtf_token_splitter.sv
// self-checking testbench for rtf_token_splitter: byte stream in, classified beat out
// depends on rts_pkg and rtf_token_splitter; the scan is predicted in the bench itself
`timescale 1ns / 1ps

module testbench;
    import rts_pkg::*;

    typedef enum int {
        PH_RECV_SLOW,
        PH_SEND_SLOW,
        PH_FULL_RATE
    } t_phase;

    typedef struct {
        bit          drain;
        t_phase      phase;
        logic [7:0]  value;
    } t_feed_item;

    typedef struct packed {
        logic [TEXT_BYTE_W-1:0]  text;
        logic                    kept;
        logic                    first;
        t_token_kind             kind;
        logic [TOKEN_LINE_W-1:0] line;
        logic [TOKEN_COL_W-1:0]  column;
    } t_token_beat;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [TEXT_BYTE_W-1:0]   i_text_byte = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [TEXT_BYTE_W-1:0]   o_out_byte;
    logic                     o_kept;
    logic                     o_token_first;
    logic [TOKEN_KIND_W-1:0]  o_token_kind;
    logic [TOKEN_LINE_W-1:0]  o_token_line;
    logic [TOKEN_COL_W-1:0]   o_token_column;

    rtf_token_splitter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_kept         (o_kept),
        .o_token_first  (o_token_first),
        .o_token_kind   (o_token_kind),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_feed_item  feed_q[$];
    t_token_beat token_q[$];
    int          fault_count = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    bit          offer = 1'b0;
    bit          byte_took = 1'b0;

    // scanner state of the predictor
    t_scan_mode              scan_state = MODE_BETWEEN;
    logic [TOKEN_LINE_W-1:0] at_line = '0;
    logic [TOKEN_COL_W-1:0]  at_col = '0;
    logic [TOKEN_LINE_W-1:0] tok_line = '0;
    logic [TOKEN_COL_W-1:0]  tok_col = '0;
    bit                      text_done = 1'b0;

    function automatic logic alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic numeral(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [TOKEN_COL_W-1:0] bump_col(input logic [TOKEN_COL_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [TOKEN_LINE_W-1:0] bump_line(input logic [TOKEN_LINE_W-1:0] l);
        return (&l) ? l : l + 1'b1;
    endfunction

    task automatic scan_byte(input logic [7:0] b, output t_token_beat r);
        bit          fall;
        bit          kept;
        bit          first;
        t_token_kind kind;
        fall  = 1'b0;
        kept  = 1'b0;
        first = 1'b0;
        kind  = KIND_BRACE;
        if (text_done) begin
            fall = 1'b0;
        end else if (b == CH_NUL) begin
            text_done  = 1'b1;
            scan_state = MODE_BETWEEN;
        end else begin
            case (scan_state)
                MODE_ESCAPE: begin
                    at_col = bump_col(at_col);
                    kept   = 1'b1;
                    if (alpha(b)) begin
                        scan_state = MODE_LETTERS;
                        kind       = KIND_WORD;
                    end else begin
                        scan_state = MODE_BETWEEN;
                        kind       = KIND_SYMBOL;
                        if (b == CH_LF) begin
                            at_line = bump_line(at_line);
                            at_col  = '0;
                        end
                    end
                end
                MODE_LETTERS: begin
                    if (alpha(b)) begin
                        at_col = bump_col(at_col);
                        kept   = 1'b1;
                        kind   = KIND_WORD;
                    end else if (b == CH_MINUS || numeral(b)) begin
                        at_col     = bump_col(at_col);
                        scan_state = MODE_DIGITS;
                        kept       = 1'b1;
                        kind       = KIND_WORD;
                    end else if (b == CH_SPACE) begin
                        at_col     = bump_col(at_col);
                        scan_state = MODE_BETWEEN;
                    end else begin
                        fall = 1'b1;
                    end
                end
                MODE_DIGITS: begin
                    if (numeral(b)) begin
                        at_col = bump_col(at_col);
                        kept   = 1'b1;
                        kind   = KIND_WORD;
                    end else if (b == CH_SPACE) begin
                        at_col     = bump_col(at_col);
                        scan_state = MODE_BETWEEN;
                    end else begin
                        fall = 1'b1;
                    end
                end
                MODE_TEXT: begin
                    if (b != CH_BSLASH && b != CH_LBRACE && b != CH_RBRACE &&
                        b != CH_CR && b != CH_LF) begin
                        at_col = bump_col(at_col);
                        kept   = 1'b1;
                        kind   = KIND_TEXT;
                    end else begin
                        fall = 1'b1;
                    end
                end
                default: begin
                    fall = 1'b1;
                end
            endcase
            if (fall) begin
                scan_state = MODE_BETWEEN;
                if (b == CH_LF) begin
                    at_line = bump_line(at_line);
                    at_col  = '0;
                end else if (b != CH_CR) begin
                    tok_line = at_line;
                    tok_col  = at_col;
                    at_col   = bump_col(at_col);
                    kept     = 1'b1;
                    first    = 1'b1;
                    if (b == CH_LBRACE || b == CH_RBRACE) begin
                        kind = KIND_BRACE;
                    end else if (b == CH_BSLASH) begin
                        kind       = KIND_SYMBOL;
                        scan_state = MODE_ESCAPE;
                    end else begin
                        kind       = KIND_TEXT;
                        scan_state = MODE_TEXT;
                    end
                end
            end
        end
        r.text   = b;
        r.kept   = kept;
        r.first  = first;
        r.kind   = kept ? kind : KIND_BRACE;
        r.line   = kept ? tok_line : '0;
        r.column = kept ? tok_col : '0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fault_count++;
        end
    endtask

    // input side: prediction at the accepting edge
    always @(posedge i_clk) begin : accept_b
        t_token_beat beat;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            scan_byte(i_text_byte, beat);
            token_q.push_back(beat);
            byte_took = 1'b1;
        end
    end

    // driver
    always @(negedge i_clk) begin : drive_b
        t_feed_item item;
        if (byte_took) begin
            offer     = 1'b0;
            byte_took = 1'b0;
        end
        if (i_rst_n && !offer && feed_q.size() > 0) begin
            if (feed_q[0].drain) begin
                if (token_q.size() == 0)
                    item = feed_q.pop_front();
            end else if ($urandom_range(99) >= send_idle) begin
                item = feed_q.pop_front();
                case (item.phase)
                    PH_RECV_SLOW: begin
                        send_idle = 20;
                        recv_idle = 60;
                    end
                    PH_SEND_SLOW: begin
                        send_idle = 60;
                        recv_idle = 20;
                    end
                    default: begin
                        send_idle = 0;
                        recv_idle = 0;
                    end
                endcase
                i_text_byte <= item.value;
                offer = 1'b1;
            end
        end
        i_in_valid <= offer;
    end

    // monitor
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin : monitor_b
        t_token_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual byte %0h",
                         $time, o_out_byte);
                fault_count++;
            end else begin
                want = token_q.pop_front();
                check_field("out_byte", want.text, o_out_byte);
                check_field("kept", want.kept, o_kept);
                check_field("token_first", want.first, o_token_first);
                check_field("token_kind", want.kind, o_token_kind);
                check_field("token_line", want.line, o_token_line);
                check_field("token_column", want.column, o_token_column);
            end
        end
    end

    // stimulus building
    int fed_count = 0;

    task automatic put(input t_phase ph, input logic [7:0] v);
        t_feed_item item;
        item.drain = 1'b0;
        item.phase = ph;
        item.value = v;
        feed_q.push_back(item);
        fed_count++;
    endtask

    task automatic put_drain();
        t_feed_item item;
        item.drain = 1'b1;
        item.phase = PH_FULL_RATE;
        item.value = '0;
        feed_q.push_back(item);
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == CH_BSLASH || c == CH_LBRACE || c == CH_RBRACE ||
                   c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] letter_char();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(1))
            c = c - 8'h20;
        return c;
    endfunction

    task automatic add_token(input t_phase ph, input bit no_lf);
        int         pick;
        logic [7:0] c;
        pick = no_lf ? $urandom_range(0, 3) : $urandom_range(0, 9);
        case (pick)
            0: put(ph, $urandom_range(1) ? CH_LBRACE : CH_RBRACE);
            1, 6: begin
                put(ph, CH_BSLASH);
                repeat ($urandom_range(1, 6)) put(ph, letter_char());
                if ($urandom_range(1))
                    put(ph, $urandom_range(2) == 0 ? CH_MINUS
                                                   : 8'h30 + 8'($urandom_range(0, 9)));
                repeat ($urandom_range(0, 4)) put(ph, 8'h30 + 8'($urandom_range(0, 9)));
                if ($urandom_range(1))
                    put(ph, CH_SPACE);
            end
            2: begin
                put(ph, CH_BSLASH);
                do begin
                    c = 8'($urandom_range(1, 255));
                end while (alpha(c) || (no_lf && c == CH_LF));
                put(ph, c);
            end
            3, 7: repeat ($urandom_range(1, 8)) put(ph, text_char());
            4: begin
                if ($urandom_range(1))
                    put(ph, CH_CR);
                put(ph, CH_LF);
            end
            5: put(ph, CH_LF);
            default: put(ph, 8'($urandom_range(1, 255)));
        endcase
    endtask

    initial begin : stimulus_b
        logic [7:0] opening [] = '{
            CH_LBRACE, CH_BSLASH, "r", "1", CH_SPACE,
            CH_BSLASH, "A", CH_MINUS, "2", CH_LBRACE,
            "h", 8'hFF, CH_BSLASH, 8'h27, CH_BSLASH,
            CH_LF, CH_CR, CH_LF, CH_BSLASH, "b",
            "0", CH_RBRACE, CH_BSLASH, "u", CH_BSLASH
        };
        foreach (opening[k]) put(PH_RECV_SLOW, opening[k]);
        while (fed_count < 420) add_token(PH_RECV_SLOW, 1'b0);
        put_drain();
        while (fed_count < 780) add_token(PH_SEND_SLOW, 1'b0);
        put_drain();
        while (fed_count < 1000) add_token(PH_FULL_RATE, 1'b0);
        put_drain();
        fed_count = 0;
        while (fed_count < 60) add_token(PH_FULL_RATE, 1'b0);
        put_drain();
        // end of text inside a pending control word, then ignored bytes
        put(PH_FULL_RATE, CH_BSLASH);
        put(PH_FULL_RATE, "b");
        put(PH_FULL_RATE, "1");
        put(PH_FULL_RATE, CH_NUL);
        repeat (20) put(PH_FULL_RATE, 8'($urandom_range(0, 255)));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() > 0 || offer || token_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fault_count == 0)
            $display("PASS rtf_token_splitter");
        else
            $display("FAIL rtf_token_splitter");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL rtf_token_splitter");
        $finish;
    end

endmodule
